FILE: rtl/mer_pkg.sv
// Shared constants, codes and control structs of the midpoint ellipse rasterizer.
`default_nettype none

package mer_pkg;

    // Default geometry
    localparam int RADIUS_BITS_DEF = 11;
    localparam int COORD_BITS_DEF  = 12;

    // Input action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // Multiplier operand selection
    localparam logic [3:0] MUL_NONE    = 4'd0;
    localparam logic [3:0] MUL_AA      = 4'd1;
    localparam logic [3:0] MUL_BB      = 4'd2;
    localparam logic [3:0] MUL_ASQ_B   = 4'd3;
    localparam logic [3:0] MUL_HH      = 4'd4;
    localparam logic [3:0] MUL_BSQ_P   = 4'd5;
    localparam logic [3:0] MUL_YY      = 4'd6;
    localparam logic [3:0] MUL_ASQ_P   = 4'd7;
    localparam logic [3:0] MUL_ASQ_BSQ = 4'd8;

    // Datapath write-back operations
    localparam logic [3:0] WB_NONE    = 4'd0;
    localparam logic [3:0] WB_ASQ     = 4'd1;
    localparam logic [3:0] WB_BSQ     = 4'd2;
    localparam logic [3:0] WB_INIT    = 4'd3;
    localparam logic [3:0] WB_ACC_SET = 4'd4;
    localparam logic [3:0] WB_ACC_ADD = 4'd5;
    localparam logic [3:0] WB_DEC_SW  = 4'd6;
    localparam logic [3:0] WB_ADV     = 4'd7;
    localparam logic [3:0] WB_DEC_UPD = 4'd8;

    // Controller to datapath commands
    typedef struct packed {
        logic       load_in;
        logic [3:0] mul_op;
        logic [3:0] wb_op;
        logic       clr_active;
        logic       out_load;
        logic       out_points;
        logic       out_done;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic zero_axis;
        logic active;
        logic region2;
        logic sx_lt_sy;
        logic last;
    } t_stat;

endpackage

`default_nettype wire

FILE: rtl/mer_mul.sv
// Shared unsigned multiplier with a registered product.
`default_nettype none

module mer_mul #(
    parameter int A_W = 22,
    parameter int B_W = 26
) (
    input  wire logic               i_clk,
    input  wire logic [A_W-1:0]     i_a,
    input  wire logic [B_W-1:0]     i_b,
    output logic      [A_W+B_W-1:0] o_prod
);

    logic [A_W+B_W-1:0] r_prod;

    // Register every product before it is used again
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

FILE: rtl/mer_dp.sv
// Datapath: ellipse state, shared multiplier, stepping adders and output register.
`default_nettype none

module mer_dp #(
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
    parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mer_pkg::t_cmd                 i_cmd,
    output mer_pkg::t_stat                     o_stat,
    input  wire logic        [COORD_BITS-1:0]  i_center_x,
    input  wire logic        [COORD_BITS-1:0]  i_center_y,
    input  wire logic        [RADIUS_BITS-1:0] i_semi_a,
    input  wire logic        [RADIUS_BITS-1:0] i_semi_b,
    output logic                               o_points_valid,
    output logic signed      [COORD_BITS+1:0]  o_p0_x,
    output logic signed      [COORD_BITS+1:0]  o_p0_y,
    output logic signed      [COORD_BITS+1:0]  o_p1_x,
    output logic signed      [COORD_BITS+1:0]  o_p1_y,
    output logic signed      [COORD_BITS+1:0]  o_p2_x,
    output logic signed      [COORD_BITS+1:0]  o_p2_y,
    output logic signed      [COORD_BITS+1:0]  o_p3_x,
    output logic signed      [COORD_BITS+1:0]  o_p3_y,
    output logic                               o_done_res
);

    localparam int R       = RADIUS_BITS;
    localparam int C       = COORD_BITS;
    localparam int SQ_W    = 2 * R;
    localparam int PX_W    = R + 1;
    localparam int PY_W    = R + 2;
    localparam int H_W     = R + 2;
    localparam int MA_W    = SQ_W;
    localparam int MB_W    = 2 * R + 4;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int SLOPE_W = 3 * R + 3;
    localparam int DEC_W   = 3 * R + 9;
    localparam int OUT_W   = C + 2;
    localparam int SUM_W   = ((C > PY_W) ? C : PY_W) + 2;

    // Latched geometry
    logic        [C-1:0]       r_cx, r_cy;
    logic        [R-1:0]       r_sa, r_sb;
    logic        [SQ_W-1:0]    r_asq, r_bsq;
    // Walk state
    logic        [PX_W-1:0]    r_pos_x;
    logic signed [PY_W-1:0]    r_pos_y;
    logic signed [SLOPE_W-1:0] r_sx, r_sy;
    logic signed [DEC_W-1:0]   r_dec;
    logic        [PROD_W-1:0]  r_acc;
    logic                      r_diag;
    logic                      r_region2;
    logic                      r_active;
    // Output payload
    logic                      r_o_pv, r_o_done;
    logic        [OUT_W-1:0]   r_o_p0x, r_o_p0y, r_o_p1x, r_o_p2y;

    logic        [MA_W-1:0]    mul_a;
    logic        [MB_W-1:0]    mul_b;
    logic        [PROD_W-1:0]  prod;
    logic        [H_W-1:0]     h_val;
    logic        [R-1:0]       ym_abs;
    logic        [SQ_W:0]      asq_p3;
    logic        [DEC_W-1:0]   init_dec;
    logic                      diag;
    logic                      move_x, move_y;
    logic                      last;
    logic signed [SLOPE_W-1:0] term_x, term_y;
    logic        [SQ_W-1:0]    term_sq;
    logic        [SUM_W-1:0]   cx_e, cy_e, px_e, py_e;
    logic        [SUM_W-1:0]   sum_xp, sum_xm, sum_yp, sum_ym;

    // Midpoint offsets for the region-two setup
    assign h_val  = {r_pos_x, 1'b1};
    assign ym_abs = (r_pos_y == '0) ? R'(1) : R'(r_pos_y - PY_W'(1));

    // Select multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.mul_op)
            mer_pkg::MUL_AA: begin
                mul_a = MA_W'(r_sa);
                mul_b = MB_W'(r_sa);
            end
            mer_pkg::MUL_BB: begin
                mul_a = MA_W'(r_sb);
                mul_b = MB_W'(r_sb);
            end
            mer_pkg::MUL_ASQ_B: begin
                mul_a = r_asq;
                mul_b = MB_W'(r_sb);
            end
            mer_pkg::MUL_HH: begin
                mul_a = MA_W'(h_val);
                mul_b = MB_W'(h_val);
            end
            mer_pkg::MUL_BSQ_P: begin
                mul_a = r_bsq;
                mul_b = prod[MB_W-1:0];
            end
            mer_pkg::MUL_YY: begin
                mul_a = MA_W'(ym_abs);
                mul_b = MB_W'(ym_abs);
            end
            mer_pkg::MUL_ASQ_P: begin
                mul_a = r_asq;
                mul_b = MB_W'(prod[SQ_W-1:0]);
            end
            mer_pkg::MUL_ASQ_BSQ: begin
                mul_a = r_asq;
                mul_b = MB_W'(r_bsq);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    mer_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Region-one decision start: b^2 - a^2*b + (a^2 + 3) / 4
    assign asq_p3   = {1'b0, r_asq} + (SQ_W + 1)'(3);
    assign init_dec = DEC_W'(r_bsq) - DEC_W'(prod[3*R-1:0]) + DEC_W'(asq_p3[SQ_W:2]);

    // Step direction
    assign diag   = r_region2 ? (r_dec[DEC_W-1] || (r_dec == '0)) : !r_dec[DEC_W-1];
    assign move_x = !r_region2 || diag;
    assign move_y = r_region2 || diag;
    assign last   = r_region2 && (r_pos_y == '0);

    // Decision update terms with the advanced slopes
    assign term_x  = (r_diag || !r_region2) ? r_sx : '0;
    assign term_y  = (r_diag || r_region2) ? r_sy : '0;
    assign term_sq = r_region2 ? r_asq : r_bsq;

    // Mirrored point sums
    assign cx_e   = SUM_W'(r_cx);
    assign cy_e   = SUM_W'(r_cy);
    assign px_e   = SUM_W'(r_pos_x);
    assign py_e   = SUM_W'(r_pos_y);
    assign sum_xp = cx_e + px_e;
    assign sum_xm = cx_e - px_e;
    assign sum_yp = cy_e + py_e;
    assign sum_ym = cy_e - py_e;

    // Control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_region2 <= 1'b0;
        end else begin
            if (i_cmd.clr_active) begin
                r_active <= 1'b0;
            end
            unique case (i_cmd.wb_op)
                mer_pkg::WB_INIT: begin
                    r_active  <= 1'b1;
                    r_region2 <= 1'b0;
                end
                mer_pkg::WB_DEC_SW: begin
                    r_region2 <= 1'b1;
                end
                mer_pkg::WB_ADV: begin
                    if (last) begin
                        r_active <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Geometry and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cx <= i_center_x;
            r_cy <= i_center_y;
            r_sa <= i_semi_a;
            r_sb <= i_semi_b;
        end
        unique case (i_cmd.wb_op)
            mer_pkg::WB_ASQ: begin
                r_asq <= prod[SQ_W-1:0];
            end
            mer_pkg::WB_BSQ: begin
                r_bsq <= prod[SQ_W-1:0];
            end
            mer_pkg::WB_INIT: begin
                r_pos_x <= '0;
                r_pos_y <= PY_W'(r_sb);
                r_sx    <= '0;
                r_sy    <= SLOPE_W'({prod[3*R-1:0], 1'b0});
                r_dec   <= init_dec;
            end
            mer_pkg::WB_ACC_SET: begin
                r_acc <= prod >> 2;
            end
            mer_pkg::WB_ACC_ADD: begin
                r_acc <= r_acc + prod;
            end
            mer_pkg::WB_DEC_SW: begin
                r_dec <= DEC_W'(signed'(r_acc - prod));
            end
            mer_pkg::WB_ADV: begin
                r_diag <= diag;
                if (move_x) begin
                    r_pos_x <= r_pos_x + PX_W'(1);
                    r_sx    <= r_sx + SLOPE_W'({r_bsq, 1'b0});
                end
                if (move_y) begin
                    r_pos_y <= r_pos_y - PY_W'(1);
                    r_sy    <= r_sy - SLOPE_W'({r_asq, 1'b0});
                end
            end
            mer_pkg::WB_DEC_UPD: begin
                r_dec <= r_dec + DEC_W'(term_x) - DEC_W'(term_y) + DEC_W'(term_sq);
            end
            default: begin
            end
        endcase
    end

    // Output register: four mirrored points or a blank result
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_pv   <= i_cmd.out_points;
            r_o_done <= i_cmd.out_done;
            if (i_cmd.out_points) begin
                r_o_p0x <= sum_xp[OUT_W-1:0];
                r_o_p0y <= sum_yp[OUT_W-1:0];
                r_o_p1x <= sum_xm[OUT_W-1:0];
                r_o_p2y <= sum_ym[OUT_W-1:0];
            end else begin
                r_o_p0x <= '0;
                r_o_p0y <= '0;
                r_o_p1x <= '0;
                r_o_p2y <= '0;
            end
        end
    end

    assign o_stat.zero_axis = (i_semi_a == '0) || (i_semi_b == '0);
    assign o_stat.active    = r_active;
    assign o_stat.region2   = r_region2;
    assign o_stat.sx_lt_sy  = r_sx < r_sy;
    assign o_stat.last      = last;

    assign o_points_valid = r_o_pv;
    assign o_done_res     = r_o_done;
    assign o_p0_x         = r_o_p0x;
    assign o_p0_y         = r_o_p0y;
    assign o_p1_x         = r_o_p1x;
    assign o_p1_y         = r_o_p0y;
    assign o_p2_x         = r_o_p0x;
    assign o_p2_y         = r_o_p2y;
    assign o_p3_x         = r_o_p1x;
    assign o_p3_y         = r_o_p2y;

endmodule

`default_nettype wire

FILE: rtl/mer_ctrl.sv
// Controller: sequences setup multiplies, region switch and stepping; owns handshakes.
`default_nettype none

module mer_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic           i_action,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire mer_pkg::t_stat i_stat,
    output mer_pkg::t_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQA   = 4'd1;
    localparam logic [3:0] S_SQB   = 4'd2;
    localparam logic [3:0] S_MAB   = 4'd3;
    localparam logic [3:0] S_INIT  = 4'd4;
    localparam logic [3:0] S_BLANK = 4'd5;
    localparam logic [3:0] S_SWH   = 4'd6;
    localparam logic [3:0] S_SWBH  = 4'd7;
    localparam logic [3:0] S_SWY   = 4'd8;
    localparam logic [3:0] S_SWAY  = 4'd9;
    localparam logic [3:0] S_SWAB  = 4'd10;
    localparam logic [3:0] S_SWFIN = 4'd11;
    localparam logic [3:0] S_STEP  = 4'd12;
    localparam logic [3:0] S_UPD   = 4'd13;

    logic [3:0] r_state, n_state;
    logic       r_done, n_done;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    logic       in_ready;
    logic       in_xfer;

    assign out_free = !r_out_valid || i_out_ready;
    assign in_ready = (r_state == S_IDLE) || (r_state == S_UPD);
    assign in_xfer  = i_in_valid && in_ready;

    // Next state and commands
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_done  = r_done;
        unique case (r_state) inside
            S_IDLE, S_UPD: begin
                if (r_state == S_UPD) begin
                    o_cmd.wb_op = mer_pkg::WB_DEC_UPD;
                    n_state     = S_IDLE;
                end
                if (in_xfer) begin
                    if (i_action == mer_pkg::ACT_START) begin
                        o_cmd.load_in = 1'b1;
                        if (i_stat.zero_axis) begin
                            o_cmd.clr_active = 1'b1;
                            n_done           = 1'b1;
                            n_state          = S_BLANK;
                        end else begin
                            n_state = S_SQA;
                        end
                    end else if (!i_stat.active) begin
                        n_done  = 1'b1;
                        n_state = S_BLANK;
                    end else if (!i_stat.region2 && !i_stat.sx_lt_sy) begin
                        n_state = S_SWH;
                    end else begin
                        n_state = S_STEP;
                    end
                end
            end
            S_SQA: begin
                o_cmd.mul_op = mer_pkg::MUL_AA;
                n_state      = S_SQB;
            end
            S_SQB: begin
                o_cmd.wb_op  = mer_pkg::WB_ASQ;
                o_cmd.mul_op = mer_pkg::MUL_BB;
                n_state      = S_MAB;
            end
            S_MAB: begin
                o_cmd.wb_op  = mer_pkg::WB_BSQ;
                o_cmd.mul_op = mer_pkg::MUL_ASQ_B;
                n_state      = S_INIT;
            end
            S_INIT: begin
                o_cmd.wb_op = mer_pkg::WB_INIT;
                n_done      = 1'b0;
                n_state     = S_BLANK;
            end
            S_BLANK: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_done = r_done;
                    n_state        = S_IDLE;
                end
            end
            S_SWH: begin
                o_cmd.mul_op = mer_pkg::MUL_HH;
                n_state      = S_SWBH;
            end
            S_SWBH: begin
                o_cmd.mul_op = mer_pkg::MUL_BSQ_P;
                n_state      = S_SWY;
            end
            S_SWY: begin
                o_cmd.wb_op  = mer_pkg::WB_ACC_SET;
                o_cmd.mul_op = mer_pkg::MUL_YY;
                n_state      = S_SWAY;
            end
            S_SWAY: begin
                o_cmd.mul_op = mer_pkg::MUL_ASQ_P;
                n_state      = S_SWAB;
            end
            S_SWAB: begin
                o_cmd.wb_op  = mer_pkg::WB_ACC_ADD;
                o_cmd.mul_op = mer_pkg::MUL_ASQ_BSQ;
                n_state      = S_SWFIN;
            end
            S_SWFIN: begin
                o_cmd.wb_op = mer_pkg::WB_DEC_SW;
                n_state     = S_STEP;
            end
            S_STEP: begin
                if (out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_points = 1'b1;
                    o_cmd.out_done   = i_stat.last;
                    o_cmd.wb_op      = mer_pkg::WB_ADV;
                    n_state          = S_UPD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, drop on transfer
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: rtl/midpoint_ellipse_rasterizer.sv
// Step through an ellipse: a plain step item registers its result in the step state once the
// output register is free; the step that enters region two first adds multiplies on the shared
// multiplier. A start item runs three multiplies for a^2, b^2, a^2*b; a zero-axis start or a
// step while idle yields a blank result. A result held in the output register stalls the next
// delivery and new input. Synchronous active-low reset returns to idle with no ellipse active.
`default_nettype none

module midpoint_ellipse_rasterizer #(
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
    parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_action,
    input  wire logic        [COORD_BITS-1:0]  i_center_x,
    input  wire logic        [COORD_BITS-1:0]  i_center_y,
    input  wire logic        [RADIUS_BITS-1:0] i_semi_a,
    input  wire logic        [RADIUS_BITS-1:0] i_semi_b,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_points_valid,
    output logic signed      [COORD_BITS+1:0]  o_p0_x,
    output logic signed      [COORD_BITS+1:0]  o_p0_y,
    output logic signed      [COORD_BITS+1:0]  o_p1_x,
    output logic signed      [COORD_BITS+1:0]  o_p1_y,
    output logic signed      [COORD_BITS+1:0]  o_p2_x,
    output logic signed      [COORD_BITS+1:0]  o_p2_y,
    output logic signed      [COORD_BITS+1:0]  o_p3_x,
    output logic signed      [COORD_BITS+1:0]  o_p3_y,
    output logic                               o_done_res
);

    mer_pkg::t_cmd  cmd;
    mer_pkg::t_stat stat;

    mer_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mer_dp #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_semi_a       (i_semi_a),
        .i_semi_b       (i_semi_b),
        .o_points_valid (o_points_valid),
        .o_p0_x         (o_p0_x),
        .o_p0_y         (o_p0_y),
        .o_p1_x         (o_p1_x),
        .o_p1_y         (o_p1_y),
        .o_p2_x         (o_p2_x),
        .o_p2_y         (o_p2_y),
        .o_p3_x         (o_p3_x),
        .o_p3_y         (o_p3_y),
        .o_done_res     (o_done_res)
    );

    // Blank results carry all-zero points
    a_blank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_points_valid) |->
        (o_p0_x == '0 && o_p0_y == '0 && o_p3_x == '0 && o_p3_y == '0))
        else $error("blank result with nonzero points");

    // Region-two decision is taken right after the a^2*b^2 product
    a_switch_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.wb_op == mer_pkg::WB_DEC_SW) |-> ($past(cmd.mul_op) == mer_pkg::MUL_ASQ_BSQ))
        else $error("region-two decision without a^2*b^2 product");

    // Setup uses the a^2*b product issued right before it
    a_init_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.wb_op == mer_pkg::WB_INIT) |-> ($past(cmd.mul_op) == mer_pkg::MUL_ASQ_B))
        else $error("setup without a^2*b product");

    // Region two is left only by a new ellipse setup
    a_region_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(stat.region2) && $past(i_rst_n)) |-> ($past(cmd.wb_op) == mer_pkg::WB_INIT))
        else $error("region flag cleared outside setup");

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the midpoint ellipse rasterizer: outlines, idle and abandon cases.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W  = mer_pkg::COORD_BITS_DEF;
    localparam int RADIUS_W = mer_pkg::RADIUS_BITS_DEF;
    localparam int OUT_W    = COORD_W + 2;
    localparam int N_ITEMS  = 1650;
    localparam int NO_LIMIT = 100000;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 16;

    typedef logic signed [63:0] t_wide;

    // One input command of the rasterizer
    typedef struct packed {
        logic                action;
        logic [COORD_W-1:0]  center_x;
        logic [COORD_W-1:0]  center_y;
        logic [RADIUS_W-1:0] semi_a;
        logic [RADIUS_W-1:0] semi_b;
        logic                drain;
    } t_ell_cmd;

    // Four mirrored points and the done flag
    typedef struct packed {
        logic                    points_valid;
        logic signed [OUT_W-1:0] p0_x;
        logic signed [OUT_W-1:0] p0_y;
        logic signed [OUT_W-1:0] p1_x;
        logic signed [OUT_W-1:0] p1_y;
        logic signed [OUT_W-1:0] p2_x;
        logic signed [OUT_W-1:0] p2_y;
        logic signed [OUT_W-1:0] p3_x;
        logic signed [OUT_W-1:0] p3_y;
        logic                    done;
    } t_quad_pts;

    // Walker state: offset, slopes, decision, region and latched geometry
    typedef struct packed {
        t_wide off_x;
        t_wide off_y;
        t_wide slope_x;
        t_wide slope_y;
        t_wide dec;
        logic  region_two;
        logic  drawing;
        t_wide a_sq;
        t_wide b_sq;
        t_wide ctr_col;
        t_wide ctr_row;
    } t_walker;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic                    i_action = mer_pkg::ACT_STEP;
    logic [COORD_W-1:0]      i_center_x = '0;
    logic [COORD_W-1:0]      i_center_y = '0;
    logic [RADIUS_W-1:0]     i_semi_a = '0;
    logic [RADIUS_W-1:0]     i_semi_b = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic                    o_points_valid;
    logic signed [OUT_W-1:0] o_p0_x, o_p0_y, o_p1_x, o_p1_y;
    logic signed [OUT_W-1:0] o_p2_x, o_p2_y, o_p3_x, o_p3_y;
    logic                    o_done_res;

    midpoint_ellipse_rasterizer u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_semi_a       (i_semi_a),
        .i_semi_b       (i_semi_b),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_points_valid (o_points_valid),
        .o_p0_x         (o_p0_x),
        .o_p0_y         (o_p0_y),
        .o_p1_x         (o_p1_x),
        .o_p1_y         (o_p1_y),
        .o_p2_x         (o_p2_x),
        .o_p2_y         (o_p2_y),
        .o_p3_x         (o_p3_x),
        .o_p3_y         (o_p3_y),
        .o_done_res     (o_done_res)
    );

    t_ell_cmd  ell_cmd_q[$];
    t_quad_pts expected_pts_q[$];
    t_walker   plan_walker;
    t_walker   check_walker;
    t_ell_cmd  cur_cmd;
    t_quad_pts walk_pts;
    t_quad_pts want_pts;
    logic      drain_req = 1'b0;
    int        n_queued = 0;
    int        n_starts = 0;
    int        n_steps = 0;
    int        n_outlines = 0;
    int        n_blank_done = 0;
    int        mismatch_cnt = 0;
    int        hold_left = 0;
    int        stall_left = 0;
    bit        drv_burst = 1'b0;
    bit        mon_burst = 1'b0;
    bit        drv_fire;
    int        quiet_cycles = 0;

    function automatic logic signed [OUT_W-1:0] to_pt(input t_wide v);
        return v[OUT_W-1:0];
    endfunction

    // Predict the result of one command and advance the walker
    function automatic void advance_outline(inout t_walker w, input t_ell_cmd c,
                                            output t_quad_pts r);
        t_wide a, b, h, ym;
        r = '0;
        if (c.action == mer_pkg::ACT_START) begin
            a = t_wide'(c.semi_a);
            b = t_wide'(c.semi_b);
            w.ctr_col = t_wide'(c.center_x);
            w.ctr_row = t_wide'(c.center_y);
            if (a == 0 || b == 0) begin
                w.drawing = 1'b0;
                r.done = 1'b1;
            end else begin
                w.a_sq = a * a;
                w.b_sq = b * b;
                w.off_x = 0;
                w.off_y = b;
                w.slope_x = 0;
                w.slope_y = 2 * w.a_sq * b;
                w.dec = w.b_sq - w.a_sq * b + (w.a_sq + 3) / 4;
                w.region_two = 1'b0;
                w.drawing = 1'b1;
            end
        end else if (!w.drawing) begin
            r.done = 1'b1;
        end else begin
            // Switch regions once the slope reaches -1, recompute the decision
            if (!w.region_two && !(w.slope_x < w.slope_y)) begin
                h = 2 * w.off_x + 1;
                ym = w.off_y - 1;
                w.region_two = 1'b1;
                w.dec = w.b_sq * (h * h) / 4 + w.a_sq * ym * ym - w.a_sq * w.b_sq;
            end
            r.points_valid = 1'b1;
            r.p0_x = to_pt(w.ctr_col + w.off_x);
            r.p0_y = to_pt(w.ctr_row + w.off_y);
            r.p1_x = to_pt(w.ctr_col - w.off_x);
            r.p1_y = to_pt(w.ctr_row + w.off_y);
            r.p2_x = to_pt(w.ctr_col + w.off_x);
            r.p2_y = to_pt(w.ctr_row - w.off_y);
            r.p3_x = to_pt(w.ctr_col - w.off_x);
            r.p3_y = to_pt(w.ctr_row - w.off_y);
            if (!w.region_two) begin
                w.off_x = w.off_x + 1;
                w.slope_x = w.slope_x + 2 * w.b_sq;
                if (w.dec < 0) begin
                    w.dec = w.dec + w.slope_x + w.b_sq;
                end else begin
                    w.off_y = w.off_y - 1;
                    w.slope_y = w.slope_y - 2 * w.a_sq;
                    w.dec = w.dec + w.slope_x - w.slope_y + w.b_sq;
                end
            end else begin
                w.off_y = w.off_y - 1;
                w.slope_y = w.slope_y - 2 * w.a_sq;
                if (w.dec > 0) begin
                    w.dec = w.dec + w.a_sq - w.slope_y;
                end else begin
                    w.off_x = w.off_x + 1;
                    w.slope_x = w.slope_x + 2 * w.b_sq;
                    w.dec = w.dec + w.slope_x - w.slope_y + w.a_sq;
                end
                if (w.off_y < 0) begin
                    w.drawing = 1'b0;
                    r.done = 1'b1;
                end
            end
        end
    endfunction

    // Queue one command; the planning walker tells when the outline ends
    task automatic push_cmd(input logic act, input logic [COORD_W-1:0] cx,
                            input logic [COORD_W-1:0] cy, input logic [RADIUS_W-1:0] sa,
                            input logic [RADIUS_W-1:0] sb, output bit fin);
        t_ell_cmd  c;
        t_quad_pts r;
        c.action = act;
        c.center_x = cx;
        c.center_y = cy;
        c.semi_a = sa;
        c.semi_b = sb;
        c.drain = drain_req;
        drain_req = 1'b0;
        advance_outline(plan_walker, c, r);
        ell_cmd_q.insert(ell_cmd_q.size(), c);
        n_queued++;
        fin = r.done;
    endtask

    task automatic push_start(input int cx, input int cy, input int sa, input int sb);
        bit fin;
        push_cmd(mer_pkg::ACT_START, COORD_W'(cx), COORD_W'(cy), RADIUS_W'(sa), RADIUS_W'(sb),
                 fin);
    endtask

    // Step fields are ignored by the block, so fill them with noise
    task automatic push_step(output bit fin);
        push_cmd(mer_pkg::ACT_STEP,
                 COORD_W'($urandom_range(0, 4095)), COORD_W'($urandom_range(0, 4095)),
                 RADIUS_W'($urandom_range(0, 2047)), RADIUS_W'($urandom_range(0, 2047)), fin);
    endtask

    task automatic run_outline(input int max_steps);
        bit fin;
        int k;
        fin = 1'b0;
        for (k = 0; k < max_steps && !fin; k++) begin
            push_step(fin);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_cnt++;
        end
    endtask

    // Clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Input driver: present queued commands with random hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            drv_fire = i_in_valid && o_in_ready;
            if (drv_fire) begin
                advance_outline(check_walker, cur_cmd, walk_pts);
                expected_pts_q.insert(expected_pts_q.size(), walk_pts);
                if (cur_cmd.action == mer_pkg::ACT_START) n_starts++;
                else n_steps++;
                if ($urandom_range(0, 49) == 0) drv_burst = !drv_burst;
                hold_left = drv_burst ? 0 : $urandom_range(0, 6);
            end
            if (drv_fire || !i_in_valid) begin
                if (hold_left > 0) begin
                    hold_left--;
                    i_in_valid <= 1'b0;
                end else if (ell_cmd_q.size() > 0 &&
                             !(ell_cmd_q[0].drain && expected_pts_q.size() != 0)) begin
                    cur_cmd = ell_cmd_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_action   <= cur_cmd.action;
                    i_center_x <= cur_cmd.center_x;
                    i_center_y <= cur_cmd.center_y;
                    i_semi_a   <= cur_cmd.semi_a;
                    i_semi_b   <= cur_cmd.semi_b;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: compare each transfer with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_pts_q.size() == 0) begin
                    $error("result transfer with no prediction pending");
                    mismatch_cnt++;
                end else begin
                    want_pts = expected_pts_q.pop_front();
                    check_field("points_valid", want_pts.points_valid, o_points_valid);
                    check_field("p0_x", want_pts.p0_x, o_p0_x);
                    check_field("p0_y", want_pts.p0_y, o_p0_y);
                    check_field("p1_x", want_pts.p1_x, o_p1_x);
                    check_field("p1_y", want_pts.p1_y, o_p1_y);
                    check_field("p2_x", want_pts.p2_x, o_p2_x);
                    check_field("p2_y", want_pts.p2_y, o_p2_y);
                    check_field("p3_x", want_pts.p3_x, o_p3_x);
                    check_field("p3_y", want_pts.p3_y, o_p3_y);
                    check_field("done_res", want_pts.done, o_done_res);
                end
                if (o_points_valid && o_done_res) n_outlines++;
                if (!o_points_valid && o_done_res) n_blank_done++;
                if ($urandom_range(0, 49) == 0) mon_burst = !mon_burst;
                stall_left = mon_burst ? 0 : $urandom_range(0, 6);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: abort when no transfer happens for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb failed");
                $finish;
            end
        end
    end

    // Stimulus plan, reset and end of run
    initial begin
        bit fin;
        int pick;
        int sel;
        int sa;
        int sb;
        int lim;
        bit drained;
        drained = 1'b0;
        plan_walker = '0;
        check_walker = '0;

        // Directed: idle step, zero axes, extreme centres and axes, tiny outlines
        push_cmd(mer_pkg::ACT_STEP, '1, '1, '1, '1, fin);
        push_start(5, 9, 0, 5);
        push_cmd(mer_pkg::ACT_STEP, '0, '0, '0, '0, fin);
        push_start(4095, 0, 7, 0);
        push_start(4095, 4095, 2047, 2047);
        run_outline(2);
        push_start(0, 0, 2047, 2047);
        run_outline(2);
        push_start(0, 4095, 2047, 1);
        run_outline(2);
        push_start(4095, 0, 1, 2047);
        run_outline(2);
        push_start(100, 200, 1, 1);
        run_outline(NO_LIMIT);
        push_step(fin);
        push_start(2000, 1000, 3, 2);
        run_outline(NO_LIMIT);

        // Random: mostly complete outlines, some abandoned, some noise
        while (n_queued < N_ITEMS) begin
            if (!drained && n_queued >= N_ITEMS / 2) begin
                drain_req = 1'b1;
                drained = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                push_step(fin);
            end else if (pick < 10) begin
                sel = $urandom_range(0, 2);
                sa = (sel == 1) ? $urandom_range(1, 2047) : 0;
                sb = (sel == 2) ? $urandom_range(1, 2047) : 0;
                push_start($urandom_range(0, 4095), $urandom_range(0, 4095), sa, sb);
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 75) begin
                    sa = $urandom_range(1, 24);
                    sb = $urandom_range(1, 24);
                    lim = (sel < 70) ? NO_LIMIT : $urandom_range(1, 20);
                end else if (sel < 90) begin
                    sa = $urandom_range(1, 100);
                    sb = $urandom_range(1, 100);
                    lim = NO_LIMIT;
                end else begin
                    // Large axis: walk only the start of it, then abandon
                    sa = $urandom_range(1, 2047);
                    sb = $urandom_range(1, 16);
                    if ($urandom_range(0, 1) == 1) begin
                        lim = sa;
                        sa = sb;
                        sb = lim;
                    end
                    lim = $urandom_range(2, 30);
                end
                push_start($urandom_range(0, 4095), $urandom_range(0, 4095), sa, sb);
                run_outline(lim);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all commands sent and every prediction matched
        @(posedge i_clk);
        while (!(ell_cmd_q.size() == 0 && !i_in_valid && expected_pts_q.size() == 0)) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d starts and %0d steps; %0d outlines ran to the end, %0d blank done",
                 n_starts, n_steps, n_outlines, n_blank_done);
        if (mismatch_cnt == 0 && expected_pts_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
